[design/sbps_pkg.sv]
`default_nettype none
package sbps_pkg;

  localparam int POSITIONS   = 18;
  localparam int REG_BYTES   = 5;
  localparam int MAPPED_POS  = 12;
  localparam int FRAME_W     = 8 * REG_BYTES;
  localparam int POS_W       = $clog2(POSITIONS);
  localparam int CNT_W       = $clog2(POSITIONS + 1);
  localparam int LIMIT_W     = 5;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int MS_W        = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int BITIDX_W    = $clog2(FRAME_W) + 2;

  // Configuration register indexes
  localparam logic [1:0] REG_BATCH_LIMIT  = 2'd0;
  localparam logic [1:0] REG_ENERGIZE_MS  = 2'd1;
  localparam logic [1:0] REG_BATCH_GAP_MS = 2'd2;
  localparam logic [1:0] REG_PHASE_GAP_MS = 2'd3;

  localparam logic [LIMIT_W-1:0] RST_BATCH_LIMIT  = 5'd10;
  localparam logic [MS_W-1:0]    RST_ENERGIZE_MS  = 8'd14;
  localparam logic [MS_W-1:0]    RST_BATCH_GAP_MS = 8'd12;
  localparam logic [MS_W-1:0]    RST_PHASE_GAP_MS = 8'd20;

  typedef struct packed {
    logic [LIMIT_W-1:0] batch_limit;
    logic [MS_W-1:0]    energize_ms;
    logic [MS_W-1:0]    batch_gap_ms;
    logic [MS_W-1:0]    phase_gap_ms;
  } cfg_t;

  // One queued pattern with its front-end classification
  typedef struct packed {
    logic [POSITIONS-1:0] pattern;
    logic                 raise_any;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOWER,
    ST_RAISE
  } back_state_t;

  // Driver bit of one position; unmapped positions give zero
  function automatic logic [FRAME_W-1:0] pos_bit(input logic [POS_W-1:0] p,
                                                 input logic lowering);
    logic [BITIDX_W-1:0] byte_idx;
    logic [BITIDX_W-1:0] bit_idx;
    byte_idx = BITIDX_W'(p >> 2) + BITIDX_W'(1);
    bit_idx  = BITIDX_W'(byte_idx << 3) + BITIDX_W'({p[1:0], 1'b0})
             + BITIDX_W'(lowering);
    if ((BITIDX_W'(p) < BITIDX_W'(MAPPED_POS)) && (byte_idx < BITIDX_W'(REG_BYTES))) begin
      pos_bit = FRAME_W'(1) << bit_idx;
    end else begin
      pos_bit = '0;
    end
  endfunction

endpackage
`default_nettype wire

[design/sbps_queue.sv]
`default_nettype none
module sbps_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sbps_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output sbps_pkg::job_t     pop_data
);

  sbps_pkg::job_t                  mem_r [sbps_pkg::QUEUE_DEPTH];
  logic [sbps_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sbps_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sbps_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == sbps_pkg::QCNT_W'(sbps_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sbps_pkg::QPTR_W'(sbps_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_r + sbps_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbps_pkg::QPTR_W'(sbps_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_r + sbps_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + sbps_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - sbps_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[design/sbps_front.sv]
`default_nettype none
module sbps_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sbps_pkg::POSITIONS-1:0] in_pin_pattern,
  input  wire logic                          job_pop,
  output logic                               job_avail,
  output sbps_pkg::job_t                     job
);

  logic           q_full;
  logic           push;
  sbps_pkg::job_t push_data;

  // Classify: a pattern with no set bit has no raise phase
  assign push_data.pattern   = in_pin_pattern;
  assign push_data.raise_any = |in_pin_pattern;
  assign in_stall            = q_full;
  assign push                = in_valid && !q_full;

  sbps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (job_pop),
    .not_empty (job_avail),
    .pop_data  (job)
  );

endmodule
`default_nettype wire

[design/sbps_back.sv]
`default_nettype none
module sbps_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sbps_pkg::cfg_t               cfg,
  input  wire logic                         job_avail,
  input  wire sbps_pkg::job_t               job,
  output logic                              job_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sbps_pkg::FRAME_W-1:0]      out_frame_image,
  output logic [sbps_pkg::MS_W-1:0]         out_on_ms,
  output logic [sbps_pkg::MS_W-1:0]         out_off_ms,
  output logic                              out_phase,
  output logic                              out_last
);

  sbps_pkg::back_state_t           state_r, state_nxt;
  logic [sbps_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [sbps_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [sbps_pkg::FRAME_W-1:0]    image_r, image_nxt;
  logic [sbps_pkg::POSITIONS-1:0]  pat_r, pat_nxt;
  logic                            raise_any_r, raise_any_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [sbps_pkg::FRAME_W-1:0]    frame_r;
  logic [sbps_pkg::MS_W-1:0]       on_r, off_r;
  logic                            phase_r, last_r;

  logic                            out_free, adv, lowering, visit, end_pos;
  logic                            full_batch, partial, emit, emit_last;
  logic [sbps_pkg::CNT_W-1:0]      cnt_inc;
  logic [sbps_pkg::FRAME_W-1:0]    img_inc;
  logic [sbps_pkg::MS_W-1:0]       off_val;

  assign out_free = !out_valid_r || !out_stall;
  assign lowering = (state_r == sbps_pkg::ST_LOWER);
  assign adv      = (state_r != sbps_pkg::ST_IDLE) && out_free;
  // Raise counts only set positions; pat_r shifts so bit 0 is the current one
  assign visit    = lowering || pat_r[0];
  assign end_pos  = (pos_r == sbps_pkg::POS_W'(sbps_pkg::POSITIONS - 1));
  assign cnt_inc  = count_r + sbps_pkg::CNT_W'(visit);
  assign img_inc  = image_r | (visit ? sbps_pkg::pos_bit(pos_r, lowering) : '0);
  assign full_batch = visit &&
      (sbps_pkg::CMP_W'(cnt_inc) >= sbps_pkg::CMP_W'(cfg.batch_limit));
  assign partial  = !full_batch && end_pos && (cnt_inc != '0);
  assign emit     = adv && (full_batch || partial);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbps_pkg::ST_IDLE: begin
        if (job_avail) begin
          state_nxt = sbps_pkg::ST_LOWER;
        end
      end
      sbps_pkg::ST_LOWER: begin
        if (adv && end_pos) begin
          state_nxt = raise_any_r ? sbps_pkg::ST_RAISE : sbps_pkg::ST_IDLE;
        end
      end
      sbps_pkg::ST_RAISE: begin
        if (adv && end_pos) begin
          state_nxt = sbps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbps_pkg::ST_IDLE;
    endcase
  end

  // Walker datapath and frame attributes
  always_comb begin
    job_pop       = 1'b0;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    image_nxt     = image_r;
    pat_nxt       = pat_r;
    raise_any_nxt = raise_any_r;
    emit_last     = 1'b0;
    off_val       = '0;
    unique case (state_r)
      sbps_pkg::ST_IDLE: begin
        job_pop = job_avail;
        if (job_avail) begin
          pos_nxt       = '0;
          count_nxt     = '0;
          image_nxt     = '0;
          pat_nxt       = job.pattern;
          raise_any_nxt = job.raise_any;
        end
      end
      sbps_pkg::ST_LOWER: begin
        off_val   = full_batch ? cfg.batch_gap_ms : cfg.phase_gap_ms;
        emit_last = end_pos && !raise_any_r;
        if (adv) begin
          pos_nxt   = end_pos ? '0 : pos_r + sbps_pkg::POS_W'(1);
          count_nxt = (full_batch || end_pos) ? '0 : cnt_inc;
          image_nxt = (full_batch || end_pos) ? '0 : img_inc;
        end
      end
      sbps_pkg::ST_RAISE: begin
        off_val   = full_batch ? cfg.batch_gap_ms : '0;
        // Last when no set position remains beyond this one
        emit_last = partial || !(|pat_r[sbps_pkg::POSITIONS-1:1]);
        if (adv) begin
          pos_nxt   = end_pos ? '0 : pos_r + sbps_pkg::POS_W'(1);
          count_nxt = (full_batch || end_pos) ? '0 : cnt_inc;
          image_nxt = (full_batch || end_pos) ? '0 : img_inc;
          pat_nxt   = pat_r >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    count_r     <= count_nxt;
    image_r     <= image_nxt;
    pat_r       <= pat_nxt;
    raise_any_r <= raise_any_nxt;
    if (emit) begin
      frame_r <= img_inc;
      on_r    <= cfg.energize_ms;
      off_r   <= off_val;
      phase_r <= !lowering;
      last_r  <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_image = frame_r;
  assign out_on_ms       = on_r;
  assign out_off_ms      = off_r;
  assign out_phase       = phase_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

[design/solenoid_batch_pulse_sequencer.sv]
`default_nettype none
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_pin_pattern[17:0]
// out_     output     out_valid/out_stall out_frame_image[39:0], out_on_ms, out_off_ms,
//                                        out_phase, out_last
// cfg_     input      cfg_valid/cfg_ready cfg_index[1:0], cfg_data[7:0]
//
// In the back end each pattern is first pulled off the queue; then the lowering
// walk and the raise walk each step through all 18 positions in order.
// The raise walk is skipped for an all-zero pattern.
// At most one frame is produced per cycle; a stalled output freezes the walk.
// A two-entry queue keeps accepting patterns while the back end is busy.
// Synchronous active-low reset clears control state and loads register defaults.
module solenoid_batch_pulse_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [sbps_pkg::POSITIONS-1:0] in_pin_pattern,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sbps_pkg::FRAME_W-1:0]        out_frame_image,
  output logic [sbps_pkg::MS_W-1:0]           out_on_ms,
  output logic [sbps_pkg::MS_W-1:0]           out_off_ms,
  output logic                                out_phase,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [sbps_pkg::MS_W-1:0]      cfg_data
);

  sbps_pkg::cfg_t cfg_r, cfg_nxt;
  logic           job_pop;
  logic           job_avail;
  sbps_pkg::job_t job;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  // Decode a configuration transaction into the register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sbps_pkg::REG_BATCH_LIMIT:  cfg_nxt.batch_limit  = cfg_data[sbps_pkg::LIMIT_W-1:0];
        sbps_pkg::REG_ENERGIZE_MS:  cfg_nxt.energize_ms  = cfg_data;
        sbps_pkg::REG_BATCH_GAP_MS: cfg_nxt.batch_gap_ms = cfg_data;
        sbps_pkg::REG_PHASE_GAP_MS: cfg_nxt.phase_gap_ms = cfg_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.batch_limit  <= sbps_pkg::RST_BATCH_LIMIT;
      cfg_r.energize_ms  <= sbps_pkg::RST_ENERGIZE_MS;
      cfg_r.batch_gap_ms <= sbps_pkg::RST_BATCH_GAP_MS;
      cfg_r.phase_gap_ms <= sbps_pkg::RST_PHASE_GAP_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept and classify patterns, hold them in the queue
  sbps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pin_pattern (in_pin_pattern),
    .job_pop        (job_pop),
    .job_avail      (job_avail),
    .job            (job)
  );

  // Back end: walk positions, batch them and emit frames
  sbps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job_avail       (job_avail),
    .job             (job),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_image (out_frame_image),
    .out_on_ms       (out_on_ms),
    .out_off_ms      (out_off_ms),
    .out_phase       (out_phase),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

[test/sbps_frame_checker.sv]
`default_nettype none
module sbps_frame_checker
  import sbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [POSITIONS-1:0] in_pin_pattern,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [FRAME_W-1:0]   out_frame_image,
  input  wire logic [MS_W-1:0]      out_on_ms,
  input  wire logic [MS_W-1:0]      out_off_ms,
  input  wire logic                 out_phase,
  input  wire logic                 out_last,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [MS_W-1:0]      cfg_data,
  output int                        mismatch_count,
  output int                        frames_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAME_W-1:0] image;
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    off_ms;
    logic               phase;
    logic               last;
  } frame_t;

  frame_t             frames_due[$];
  logic [LIMIT_W-1:0] limit_r;
  logic [MS_W-1:0]    pulse_r;
  logic [MS_W-1:0]    batch_gap_r;
  logic [MS_W-1:0]    phase_gap_r;

  initial begin
    mismatch_count     = 0;
    frames_outstanding = 0;
  end

  // Walk one phase and queue the frames it emits
  function automatic void walk_phase(input logic [POSITIONS-1:0] pat, input bit raising);
    logic [FRAME_W-1:0] image;
    logic [MS_W-1:0]    tail_off;
    int                 count;
    int                 byte_no;
    image    = '0;
    count    = 0;
    tail_off = raising ? '0 : phase_gap_r;
    for (int p = 0; p < POSITIONS; p++) begin
      if (raising && !pat[p]) continue;
      byte_no = 1 + p / 4;
      if (p < MAPPED_POS && byte_no < REG_BYTES) begin
        image[8 * byte_no + 2 * (p % 4) + (raising ? 0 : 1)] = 1'b1;
      end
      count++;
      if (count >= limit_r) begin
        frames_due.push_back('{image, pulse_r, batch_gap_r, raising, 1'b0});
        image = '0;
        count = 0;
      end
    end
    if (count > 0) begin
      frames_due.push_back('{image, pulse_r, tail_off, raising, 1'b0});
    end
  endfunction

  function automatic void predict_pattern_frames(input logic [POSITIONS-1:0] pat);
    walk_phase(pat, 1'b0);
    walk_phase(pat, 1'b1);
    frames_due[frames_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      limit_r     = RST_BATCH_LIMIT;
      pulse_r     = RST_ENERGIZE_MS;
      batch_gap_r = RST_BATCH_GAP_MS;
      phase_gap_r = RST_PHASE_GAP_MS;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BATCH_LIMIT:  limit_r     = cfg_data[LIMIT_W-1:0];
          REG_ENERGIZE_MS:  pulse_r     = cfg_data;
          REG_BATCH_GAP_MS: batch_gap_r = cfg_data;
          REG_PHASE_GAP_MS: phase_gap_r = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: frame_image %h", out_frame_image);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          if (out_frame_image !== want.image) begin
            $error("frame_image expected %h actual %h", want.image, out_frame_image);
            mismatch_count++;
          end
          if (out_on_ms !== want.on_ms) begin
            $error("on_ms expected %0d actual %0d", want.on_ms, out_on_ms);
            mismatch_count++;
          end
          if (out_off_ms !== want.off_ms) begin
            $error("off_ms expected %0d actual %0d", want.off_ms, out_off_ms);
            mismatch_count++;
          end
          if (out_phase !== want.phase) begin
            $error("phase expected %0d actual %0d", want.phase, out_phase);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_pattern_frames(in_pin_pattern);
      end
    end
    frames_outstanding <= frames_due.size();
  end

endmodule
`default_nettype wire

[test/solenoid_batch_pulse_sequencer_tb.sv]
`default_nettype none
module solenoid_batch_pulse_sequencer_tb;
  import sbps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // Extra settling after the last predicted frame so the back end returns to idle
  localparam int DRAIN_CYCLES   = 45;
  // Receiver hold-off long enough to fill the two-entry pattern queue
  localparam int HOLD_CYCLES    = 250;
  localparam int PLAN_ROWS      = 8;
  localparam int ITEMS_PER_ROW  = 15;

  // Register plan per phase: batch_limit, energize_ms, batch_gap_ms, phase_gap_ms.
  // Batch limit rows cover one, zero, the full walk, the 5-bit maximum,
  // upper data bits that get truncated (0xE6 gives 6), an even divisor of
  // the walk, one above the walk and a small even size.
  localparam logic [7:0] REG_PLAN [PLAN_ROWS][4] = '{
    '{8'd1,   8'd0,   8'd255, 8'd0  },
    '{8'd0,   8'd255, 8'd0,   8'd255},
    '{8'd18,  8'd14,  8'd12,  8'd20 },
    '{8'd31,  8'd170, 8'd85,  8'd60 },
    '{8'hE6,  8'd85,  8'd170, 8'd3  },
    '{8'd9,   8'd1,   8'd254, 8'd128},
    '{8'd19,  8'd128, 8'd1,   8'd254},
    '{8'd4,   8'd37,  8'd99,  8'd200}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [POSITIONS-1:0] in_pin_pattern;
  logic                 out_valid;
  logic                 out_stall;
  logic [FRAME_W-1:0]   out_frame_image;
  logic [MS_W-1:0]      out_on_ms;
  logic [MS_W-1:0]      out_off_ms;
  logic                 out_phase;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [MS_W-1:0]      cfg_data;

  int mismatch_count;
  int frames_outstanding;
  int idle_cycles;
  bit hold_req;

  solenoid_batch_pulse_sequencer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pin_pattern  (in_pin_pattern),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_image (out_frame_image),
    .out_on_ms       (out_on_ms),
    .out_off_ms      (out_off_ms),
    .out_phase       (out_phase),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  sbps_frame_checker frame_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_pattern     (in_pin_pattern),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_image    (out_frame_image),
    .out_on_ms          (out_on_ms),
    .out_off_ms         (out_off_ms),
    .out_phase          (out_phase),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .frames_outstanding (frames_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles in which no channel completes a transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall in stretches of random density, including stall-free
  // stretches; on request hold off for a long fixed stretch.
  initial begin : receiver
    int hold_left;
    int mode_left;
    int stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 60;
          endcase
          mode_left = $urandom_range(80, 20);
        end
        mode_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one pattern and hold it until the block takes it; valid is left
  // high so a following call can chain without a bubble.
  task automatic send_pattern(input logic [POSITIONS-1:0] pat);
    in_valid       <= 1'b1;
    in_pin_pattern <= pat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted frame, then let the back end settle
  task automatic drain_frames();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [MS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [POSITIONS-1:0] random_pattern();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return POSITIONS'(1) << $urandom_range(POSITIONS - 1);
      default: return POSITIONS'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int burst_left;
    int gap;
    rst_n          = 1'b0;
    hold_req       = 1'b0;
    in_valid       = 1'b0;
    in_pin_pattern = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_BATCH_LIMIT;
    cfg_data       = '0;
    burst_left     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed patterns under the reset register values, back to back
    send_pattern('0);                        // empty raise set
    send_pattern('1);                        // every position raised
    send_pattern(18'h00001);                 // first position only
    send_pattern(18'h00800);                 // last mapped position
    send_pattern(18'h01000);                 // first unmapped position
    send_pattern(18'h20000);                 // last position
    send_pattern(18'h15555);
    send_pattern(18'h2AAAA);
    send_pattern(18'h00FFF);                 // mapped positions only
    send_pattern(18'h3F000);                 // unmapped only, all-zero raise frame
    send_pattern(18'h003FF);                 // raise phase ends on a full batch
    drain_frames();

    for (int k = 0; k < PLAN_ROWS; k++) begin
      write_reg(REG_BATCH_LIMIT,  REG_PLAN[k][0]);
      write_reg(REG_ENERGIZE_MS,  REG_PLAN[k][1]);
      write_reg(REG_BATCH_GAP_MS, REG_PLAN[k][2]);
      write_reg(REG_PHASE_GAP_MS, REG_PLAN[k][3]);
      cfg_valid <= 1'b0;
      @(posedge clk);

      // Long receiver hold-off while the sender keeps pushing
      if (k == 2) begin
        hold_req   = 1'b1;
        burst_left = ITEMS_PER_ROW;
      end

      for (int n = 0; n < ITEMS_PER_ROW; n++) begin
        // Sender pauses mid-phase until every frame has arrived
        if (k == 5 && n == 7) drain_frames();
        if (burst_left == 0) begin
          gap = $urandom_range(6);
          if (gap > 0) pause_sender(gap);
          burst_left = $urandom_range(10, 1);
        end
        burst_left--;
        send_pattern(random_pattern());
      end
      drain_frames();
    end

    if (mismatch_count == 0 && frames_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
